### rtl/c_subset_lexer_assert.svh
// Assertion macros for the lexer RTL.
`ifndef C_SUBSET_LEXER_ASSERT_SVH
`define C_SUBSET_LEXER_ASSERT_SVH

// same-cycle implication
`define CLX_ASSERT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("lexer assertion failed");

// next-cycle implication
`define CLX_ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("lexer assertion failed");

`endif

### rtl/c_lex_pkg.sv
`default_nettype none
package c_lex_pkg;

  localparam int POSITION_BITS = 16;
  localparam int FIELD_BITS    = 16;
  localparam int LIMIT_BITS    = 16;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd1024;

  localparam int ITEM_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH  = 4;
  localparam int RES_PW       = $clog2(RES_Q_DEPTH);
  localparam int RES_CW       = RES_PW + 1;

  // token kinds
  localparam logic [5:0] K_END       = 6'd0;
  localparam logic [5:0] K_IDENT     = 6'd1;
  localparam logic [5:0] K_NUMBER    = 6'd2;
  localparam logic [5:0] K_STRING    = 6'd3;
  localparam logic [5:0] K_CHAR_LIT  = 6'd4;
  localparam logic [5:0] K_KW_CHAR   = 6'd5;
  localparam logic [5:0] K_KW_INT    = 6'd6;
  localparam logic [5:0] K_KW_IF     = 6'd7;
  localparam logic [5:0] K_KW_ELSE   = 6'd8;
  localparam logic [5:0] K_KW_WHILE  = 6'd9;
  localparam logic [5:0] K_KW_FOR    = 6'd10;
  localparam logic [5:0] K_KW_RETURN = 6'd11;
  localparam logic [5:0] K_LPAREN    = 6'd12;
  localparam logic [5:0] K_RPAREN    = 6'd13;
  localparam logic [5:0] K_LBRACE    = 6'd14;
  localparam logic [5:0] K_RBRACE    = 6'd15;
  localparam logic [5:0] K_LBRACK    = 6'd16;
  localparam logic [5:0] K_RBRACK    = 6'd17;
  localparam logic [5:0] K_COMMA     = 6'd18;
  localparam logic [5:0] K_SEMI      = 6'd19;
  localparam logic [5:0] K_PLUS      = 6'd20;
  localparam logic [5:0] K_MINUS     = 6'd21;
  localparam logic [5:0] K_STAR      = 6'd22;
  localparam logic [5:0] K_SLASH     = 6'd23;
  localparam logic [5:0] K_PERCENT   = 6'd24;
  localparam logic [5:0] K_NOT       = 6'd25;
  localparam logic [5:0] K_NE        = 6'd26;
  localparam logic [5:0] K_ASSIGN    = 6'd27;
  localparam logic [5:0] K_EQ        = 6'd28;
  localparam logic [5:0] K_LT        = 6'd29;
  localparam logic [5:0] K_LE        = 6'd30;
  localparam logic [5:0] K_GT        = 6'd31;
  localparam logic [5:0] K_GE        = 6'd32;
  localparam logic [5:0] K_AND       = 6'd33;
  localparam logic [5:0] K_OR        = 6'd34;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_UNTERM  = 2'd2;
  localparam logic [1:0] ST_LIMIT   = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       zero;
    logic       alpha;
    logic       digit;
    logic       blank;
    logic       nl;
    logic       dq;
    logic       sq;
    logic       bslash;
    logic       opch;
    logic [5:0] single;
  } item_t;

  typedef struct packed {
    logic [5:0]            kind;
    logic [1:0]            status;
    logic [FIELD_BITS-1:0] line;
    logic [FIELD_BITS-1:0] column;
    logic [FIELD_BITS-1:0] offset;
    logic [FIELD_BITS-1:0] length;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } wr_t;

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "[": k = K_LBRACK;
      "]": k = K_RBRACK;
      ",": k = K_COMMA;
      ";": k = K_SEMI;
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "*": k = K_STAR;
      "/": k = K_SLASH;
      "%": k = K_PERCENT;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic item_t classify(input logic [7:0] c);
    item_t it;
    it.ch     = c;
    it.zero   = (c == 8'd0);
    it.alpha  = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    it.digit  = (c >= "0" && c <= "9");
    it.blank  = (c == " ") || (c == 8'h09) || (c == 8'h0D);
    it.nl     = (c == 8'h0A);
    it.dq     = (c == 8'h22);
    it.sq     = (c == 8'h27);
    it.bslash = (c == 8'h5C);
    it.opch   = (c == "!") || (c == "=") || (c == "<") || (c == ">") ||
                (c == "&") || (c == "|");
    it.single = single_kind(c);
    return it;
  endfunction

  // n is the word length, 7 when longer than six
  function automatic logic [5:0] kw_kind(input logic [5:0][7:0] p, input logic [2:0] n);
    logic [5:0] k;
    k = K_IDENT;
    case (n)
      3'd2: if (p[0] == "i" && p[1] == "f") k = K_KW_IF;
      3'd3: begin
        if (p[0] == "i" && p[1] == "n" && p[2] == "t") k = K_KW_INT;
        else if (p[0] == "f" && p[1] == "o" && p[2] == "r") k = K_KW_FOR;
      end
      3'd4: begin
        if (p[0] == "c" && p[1] == "h" && p[2] == "a" && p[3] == "r") k = K_KW_CHAR;
        else if (p[0] == "e" && p[1] == "l" && p[2] == "s" && p[3] == "e") k = K_KW_ELSE;
      end
      3'd5: begin
        if (p[0] == "w" && p[1] == "h" && p[2] == "i" && p[3] == "l" && p[4] == "e")
          k = K_KW_WHILE;
      end
      3'd6: begin
        if (p[0] == "r" && p[1] == "e" && p[2] == "t" && p[3] == "u" && p[4] == "r" &&
            p[5] == "n")
          k = K_KW_RETURN;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### rtl/c_lex_if.sv
`default_nettype none
interface c_lex_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source(output valid, output source_byte, input ready);
  modport sink(input valid, input source_byte, output ready);
endinterface

interface c_lex_tok_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  status;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_item;
  modport source(output valid, output token_kind, output status, output start_line,
                 output start_column, output start_offset, output token_length,
                 output last_of_item, input ready);
  modport sink(input valid, input token_kind, input status, input start_line,
               input start_column, input start_offset, input token_length,
               input last_of_item, output ready);
endinterface
`default_nettype wire

### rtl/c_subset_lexer.sv
// Each accepted byte is registered in the front queue, then tokenized into the result queue.
// Throughput: one byte per cycle while tokens.ready holds; a byte that yields two tokens drains
//   them one per cycle from the 4-entry result queue; the scanner waits for two free slots.
// Reset (rst, synchronous): line and column 1, offset 0, no tokens counted, queues empty,
//   token_limit 1024. A zero byte restarts position and token count.
`default_nettype none
module c_subset_lexer #(
  parameter int POSITION_BITS = c_lex_pkg::POSITION_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [c_lex_pkg::LIMIT_BITS-1:0] cfg_wdata,
  c_lex_byte_if.sink                            chars,
  c_lex_tok_if.source                           tokens
);
  import c_lex_pkg::*;

  logic              item_valid;
  logic              item_ready;
  item_t             item;
  logic [RES_CW-1:0] res_free;
  wr_t               wr;

  c_lex_front u_front (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  c_lex_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .res_free   (res_free),
    .wr         (wr)
  );

  c_lex_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .res_free (res_free),
    .tokens   (tokens)
  );

endmodule
`default_nettype wire

### rtl/c_lex_front.sv
`default_nettype none
module c_lex_front (
  input  wire logic            clk,
  input  wire logic            rst,
  c_lex_byte_if.sink           chars,
  output logic                 item_valid,
  output c_lex_pkg::item_t     item,
  input  wire logic            item_ready
);
  import c_lex_pkg::*;

  localparam int PW = $clog2(ITEM_Q_DEPTH);

  item_t         q [ITEM_Q_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign chars.ready = (count != (PW+1)'(ITEM_Q_DEPTH));
  assign push        = chars.valid && chars.ready;
  assign item_valid  = (count != '0);
  assign pop         = item_valid && item_ready;
  assign item        = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= classify(chars.source_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + PW'(1);
      if (pop) rp <= rp + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

### rtl/c_lex_scan.sv
`default_nettype none
`include "c_subset_lexer_assert.svh"
module c_lex_scan #(
  parameter int POSITION_BITS = c_lex_pkg::POSITION_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [c_lex_pkg::LIMIT_BITS-1:0]  cfg_wdata,
  input  wire logic                              item_valid,
  input  wire c_lex_pkg::item_t                  item,
  output logic                                   item_ready,
  input  wire logic [c_lex_pkg::RES_CW-1:0]      res_free,
  output c_lex_pkg::wr_t                         wr
);
  import c_lex_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int CW = (PB > LIMIT_BITS) ? PB : LIMIT_BITS;

  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_WORD     = 3'd1;
  localparam logic [2:0] M_NUMBER   = 3'd2;
  localparam logic [2:0] M_LITERAL  = 3'd3;
  localparam logic [2:0] M_ESCAPE   = 3'd4;
  localparam logic [2:0] M_OPERATOR = 3'd5;
  localparam logic [2:0] M_ERROR    = 3'd6;

  localparam logic [1:0] P_NONE = 2'd0;
  localparam logic [1:0] P_STEP = 2'd1;
  localparam logic [1:0] P_NL   = 2'd2;

  function automatic logic [PB-1:0] sat(input logic [PB-1:0] v);
    return (v == '1) ? v : v + PB'(1);
  endfunction

  logic [LIMIT_BITS-1:0] limit;
  logic [2:0]            mode, mode_next;
  logic [5:0][7:0]       pfx, pfx_next;
  logic [7:0]            pend, pend_next;
  logic                  dq, dq_next;
  logic [PB-1:0]         line, line_next;
  logic [PB-1:0]         col, col_next;
  logic [PB-1:0]         off, off_next;
  logic [PB-1:0]         ts_line, ts_col, ts_off;
  logic [PB-1:0]         cnt, cnt_next;
  logic [PB-1:0]         run, run_next;

  logic                  take;
  logic                  mark;
  logic [1:0]            pos_act;
  logic                  more, pair, lone;
  logic                  a_push, a_fail, a_ok;
  logic [5:0]            a_kind;
  logic [1:0]            a_status;
  logic [PB-1:0]         a_len;
  logic                  go2, run2;
  logic                  b_push, b_fail, b_ok;
  logic [5:0]            b_kind;
  logic [PB-1:0]         cnt_a;
  logic                  have_a, have_b;
  logic [2:0]            kwn;
  res_t                  ra, rb;

  assign item_ready = (res_free >= RES_CW'(2));
  assign take       = item_valid && item_ready;
  assign kwn        = (run <= PB'(6)) ? run[2:0] : 3'd7;

  always_comb begin
    mode_next = mode;
    pfx_next  = pfx;
    pend_next = pend;
    dq_next   = dq;
    run_next  = run;
    pos_act   = P_NONE;
    mark      = 1'b0;
    more      = 1'b0;
    pair      = 1'b0;
    lone      = 1'b0;
    a_push    = 1'b0;
    a_fail    = 1'b0;
    a_kind    = K_END;
    a_status  = ST_OK;
    a_len     = '0;
    go2       = 1'b0;
    b_push    = 1'b0;
    b_fail    = 1'b0;
    b_kind    = K_END;

    case (mode)
      M_WORD, M_NUMBER: begin
        more = (mode == M_WORD) ? (item.alpha || item.digit) : item.digit;
        if (more) begin
          if (run < PB'(6)) pfx_next[run[2:0]] = item.ch;
          run_next = sat(run);
          pos_act  = P_STEP;
        end else begin
          a_push    = 1'b1;
          a_kind    = (mode == M_WORD) ? kw_kind(pfx, kwn) : K_NUMBER;
          a_len     = run;
          mode_next = M_IDLE;
          go2       = 1'b1;
        end
      end
      M_OPERATOR: begin
        lone      = (pend == "&") || (pend == "|");
        pair      = lone ? (item.ch == pend) : (item.ch == "=");
        mode_next = M_IDLE;
        if (pair) begin
          pos_act = P_STEP;
          a_push  = 1'b1;
          a_len   = PB'(2);
          a_kind  = (pend == "!") ? K_NE : (pend == "=") ? K_EQ : (pend == "<") ? K_LE :
                    (pend == ">") ? K_GE : (pend == "&") ? K_AND : K_OR;
        end else if (lone) begin
          a_fail   = 1'b1;
          a_status = ST_BAD;
        end else begin
          a_push = 1'b1;
          a_len  = PB'(1);
          a_kind = (pend == "!") ? K_NOT : (pend == "=") ? K_ASSIGN :
                   (pend == "<") ? K_LT : K_GT;
          go2    = 1'b1;
        end
      end
      M_LITERAL, M_ESCAPE: begin
        if (item.zero) begin
          a_fail   = 1'b1;
          a_status = ST_UNTERM;
        end else begin
          run_next = sat(run);
          if (mode == M_ESCAPE) begin
            mode_next = M_LITERAL;
            pos_act   = P_STEP;
          end else if (dq ? item.dq : item.sq) begin
            pos_act   = P_STEP;
            mode_next = M_IDLE;
            a_push    = 1'b1;
            a_kind    = dq ? K_STRING : K_CHAR_LIT;
            a_len     = sat(run);
          end else if (item.bslash) begin
            mode_next = M_ESCAPE;
            pos_act   = P_STEP;
          end else if (item.nl) begin
            pos_act = P_NL;
          end else begin
            pos_act = P_STEP;
          end
        end
      end
      M_IDLE: go2 = 1'b1;
      default: ;
    endcase

    a_ok  = CW'(cnt) < CW'(limit);
    cnt_a = (a_push && a_ok) ? sat(cnt) : cnt;
    run2  = go2 && !(a_push && !a_ok);

    if (run2) begin
      if (item.zero) begin
        b_push = 1'b1;
      end else if (item.blank) begin
        pos_act = P_STEP;
      end else if (item.nl) begin
        pos_act = P_NL;
      end else if (item.alpha || item.digit) begin
        mark        = 1'b1;
        pfx_next[0] = item.ch;
        run_next    = PB'(1);
        mode_next   = item.digit ? M_NUMBER : M_WORD;
        pos_act     = P_STEP;
      end else if (item.dq || item.sq) begin
        mark      = 1'b1;
        dq_next   = item.dq;
        run_next  = PB'(1);
        mode_next = M_LITERAL;
        pos_act   = P_STEP;
      end else if (item.opch) begin
        mark      = 1'b1;
        pend_next = item.ch;
        mode_next = M_OPERATOR;
        pos_act   = P_STEP;
      end else if (item.single != K_END) begin
        mark    = 1'b1;
        pos_act = P_STEP;
        b_push  = 1'b1;
        b_kind  = item.single;
      end else begin
        mark   = 1'b1;
        b_fail = 1'b1;
      end
    end

    b_ok     = CW'(cnt_a) < CW'(limit);
    cnt_next = (b_push && b_ok) ? sat(cnt_a) : cnt_a;

    if (a_fail || (a_push && !a_ok) || b_fail || (b_push && !b_ok)) mode_next = M_ERROR;

    line_next = line;
    col_next  = col;
    off_next  = off;
    case (pos_act)
      P_STEP: begin
        col_next = sat(col);
        off_next = sat(off);
      end
      P_NL: begin
        line_next = sat(line);
        col_next  = PB'(1);
        off_next  = sat(off);
      end
      default: ;
    endcase

    // end byte always starts the source over
    if (item.zero) begin
      mode_next = M_IDLE;
      pend_next = '0;
      dq_next   = 1'b0;
      line_next = PB'(1);
      col_next  = PB'(1);
      off_next  = '0;
      cnt_next  = '0;
      run_next  = '0;
    end

    ra.kind   = (a_push && a_ok) ? a_kind : K_END;
    ra.status = a_fail ? a_status : (a_ok ? ST_OK : ST_LIMIT);
    ra.line   = FIELD_BITS'(ts_line);
    ra.column = FIELD_BITS'(ts_col);
    ra.offset = FIELD_BITS'(ts_off);
    ra.length = (a_push && a_ok) ? FIELD_BITS'(a_len) : '0;
    ra.last   = 1'b0;

    rb.kind   = (b_push && b_ok) ? b_kind : K_END;
    rb.status = b_fail ? ST_BAD : (b_ok ? ST_OK : ST_LIMIT);
    rb.line   = FIELD_BITS'(line);
    rb.column = FIELD_BITS'(col);
    rb.offset = FIELD_BITS'(off);
    rb.length = (b_push && b_ok && !item.zero) ? FIELD_BITS'(1) : '0;
    rb.last   = 1'b1;

    have_a = take && (a_push || a_fail);
    have_b = take && run2 && (b_push || b_fail);

    wr.cnt = {1'b0, have_a} + {1'b0, have_b};
    wr.r0  = have_a ? ra : rb;
    wr.r1  = rb;
    if (have_a && !have_b) wr.r0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pfx <= pfx_next;
      if (mark) begin
        ts_line <= line;
        ts_col  <= col;
        ts_off  <= off;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
      mode  <= M_IDLE;
      pend  <= '0;
      dq    <= 1'b0;
      line  <= PB'(1);
      col   <= PB'(1);
      off   <= '0;
      cnt   <= '0;
      run   <= '0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      if (take) begin
        mode <= mode_next;
        pend <= pend_next;
        dq   <= dq_next;
        line <= line_next;
        col  <= col_next;
        off  <= off_next;
        cnt  <= cnt_next;
        run  <= run_next;
      end
    end
  end

  `CLX_ASSERT_NEXT(a_end_restarts, clk, rst, take && item.zero,
    mode == M_IDLE && line == PB'(1) && col == PB'(1) && off == '0 && cnt == '0)
  `CLX_ASSERT(a_error_silent, clk, rst, take && mode == M_ERROR, wr.cnt == 2'd0)
  `CLX_ASSERT(a_no_overrun, clk, rst, wr.cnt != 2'd0, RES_CW'(wr.cnt) <= res_free)
  `CLX_ASSERT(a_idle_single, clk, rst, mode == M_IDLE || mode == M_ERROR, wr.cnt != 2'd2)

endmodule
`default_nettype wire

### rtl/c_lex_resq.sv
`default_nettype none
module c_lex_resq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire c_lex_pkg::wr_t                wr,
  output logic [c_lex_pkg::RES_CW-1:0]       res_free,
  c_lex_tok_if.source                        tokens
);
  import c_lex_pkg::*;

  res_t              q [RES_Q_DEPTH];
  logic [RES_PW-1:0] wp;
  logic [RES_PW-1:0] rp;
  logic [RES_CW-1:0] count;
  logic              pop;
  res_t              head;

  assign res_free            = RES_CW'(RES_Q_DEPTH) - count;
  assign tokens.valid        = (count != '0);
  assign pop                 = tokens.valid && tokens.ready;
  assign head                = q[rp];
  assign tokens.token_kind   = head.kind;
  assign tokens.status       = head.status;
  assign tokens.start_line   = head.line;
  assign tokens.start_column = head.column;
  assign tokens.start_offset = head.offset;
  assign tokens.token_length = head.length;
  assign tokens.last_of_item = head.last;

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) q[wp] <= wr.r0;
    if (wr.cnt == 2'd2) q[wp + RES_PW'(1)] <= wr.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + RES_PW'(wr.cnt);
      if (pop) rp <= rp + RES_PW'(1);
      count <= count + RES_CW'(wr.cnt) - RES_CW'(pop);
    end
  end

endmodule
`default_nettype wire

### tb/sv/tb_c_subset_lexer.sv
module tb_c_subset_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  import c_lex_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 8;
  localparam int PHASE_BYTES = 250;

  localparam logic [7:0] CH_END = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_BS  = 8'h5C;

  typedef enum logic [2:0] {
    LX_IDLE, LX_WORD, LX_NUMBER, LX_LITERAL, LX_ESCAPE, LX_OPERATOR, LX_ERROR
  } scan_state_e;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    res_t       want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  c_lex_byte_if chars_if();
  c_lex_tok_if  tokens_if();

  c_subset_lexer dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .chars(chars_if),
    .tokens(tokens_if)
  );

  // lexer state as seen from outside
  scan_state_e scan_state;
  logic [7:0]  word_buf [6];
  logic [7:0]  pend_op;
  logic        quote_dq;
  logic [15:0] cur_line, cur_col, cur_off;
  logic [15:0] tok_line, tok_col, tok_off;
  logic [15:0] emitted_count, tok_limit, run_len;
  logic        lex_failed;
  int          step_out;

  res_t        pending_tokens [$];
  dir_row_t    dir_rows [$];
  logic [7:0]  src_q [$];

  int cycles = 0;
  int mismatches = 0;
  int tx_count = 0;
  int rx_count = 0;
  int rx_errors = 0;
  int src_count = 0;
  int tx_burst = 0;
  int rx_hold = 0;
  bit tx_smooth = 1'b0;
  bit rx_free = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycles++;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic letter_or_us(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic dec_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic string kw_spelling(input int i);
    case (i)
      0: return "char";
      1: return "int";
      2: return "if";
      3: return "else";
      4: return "while";
      5: return "for";
      default: return "return";
    endcase
  endfunction

  function automatic string op_text(input int i);
    case (i)
      0: return "!";
      1: return "!=";
      2: return "=";
      3: return "==";
      4: return "<";
      5: return "<=";
      6: return ">";
      7: return ">=";
      8: return "&&";
      default: return "||";
    endcase
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] b);
    string marks;
    logic [5:0] k;
    marks = "(){}[],;+-*/%";
    k = K_END;
    for (int i = 0; i < 13; i++)
      if (b == marks[i]) k = 6'(K_LPAREN + i);
    return k;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] op, input logic pair);
    case (op)
      "!": return pair ? K_NE : K_NOT;
      "=": return pair ? K_EQ : K_ASSIGN;
      "<": return pair ? K_LE : K_LT;
      ">": return pair ? K_GE : K_GT;
      "&": return K_AND;
      default: return K_OR;
    endcase
  endfunction

  function automatic logic [5:0] word_token();
    string w;
    logic [5:0] k;
    logic hit;
    k = K_IDENT;
    for (int i = 0; i < 7; i++) begin
      w = kw_spelling(i);
      hit = (run_len == w.len());
      for (int j = 0; j < w.len(); j++)
        if (word_buf[j] != w[j]) hit = 1'b0;
      if (hit) k = 6'(K_KW_CHAR + i);
    end
    return k;
  endfunction

  task automatic lex_restart();
    scan_state = LX_IDLE;
    for (int i = 0; i < 6; i++) word_buf[i] = 8'h00;
    pend_op = 8'h00;
    quote_dq = 1'b0;
    cur_line = 16'd1;
    cur_col = 16'd1;
    cur_off = 16'd0;
    tok_line = 16'd0;
    tok_col = 16'd0;
    tok_off = 16'd0;
    emitted_count = 16'd0;
    run_len = 16'd0;
  endtask

  task automatic mark_start();
    tok_line = cur_line;
    tok_col = cur_col;
    tok_off = cur_off;
    run_len = 16'd0;
  endtask

  task automatic step_col();
    cur_col = sat16(cur_col);
    cur_off = sat16(cur_off);
  endtask

  task automatic new_line();
    cur_line = sat16(cur_line);
    cur_col = 16'd1;
    cur_off = sat16(cur_off);
  endtask

  task automatic emit_result(input logic [5:0] k, input logic [1:0] st, input logic [15:0] len);
    res_t r;
    r.kind = k;
    r.status = st;
    r.line = tok_line;
    r.column = tok_col;
    r.offset = tok_off;
    r.length = len;
    r.last = 1'b0;
    pending_tokens.push_back(r);
    step_out++;
  endtask

  task automatic emit_error(input logic [1:0] st);
    lex_failed = 1'b1;
    emit_result(K_END, st, 16'd0);
  endtask

  task automatic emit_token(input logic [5:0] k, input logic [15:0] len);
    if (emitted_count >= tok_limit) begin
      emit_error(ST_LIMIT);
    end else begin
      emitted_count = sat16(emitted_count);
      emit_result(k, ST_OK, len);
    end
  endtask

  // expected tokens for one accepted byte
  task automatic lex_byte(input logic [7:0] b);
    logic [7:0] op;
    logic more, pair, fin;
    res_t last_tok;
    step_out = 0;
    lex_failed = 1'b0;
    fin = 1'b0;
    if (scan_state == LX_ERROR) begin
      if (b == CH_END) lex_restart();
    end else begin
      if (scan_state == LX_WORD || scan_state == LX_NUMBER) begin
        more = dec_digit(b) || (scan_state == LX_WORD && letter_or_us(b));
        if (more) begin
          if (run_len < 16'd6) word_buf[run_len[2:0]] = b;
          run_len = sat16(run_len);
          step_col();
          fin = 1'b1;
        end else begin
          emit_token(scan_state == LX_WORD ? word_token() : K_NUMBER, run_len);
          scan_state = LX_IDLE;
        end
      end else if (scan_state == LX_OPERATOR) begin
        op = pend_op;
        pair = (op == "&" || op == "|") ? (b == op) : (b == "=");
        scan_state = LX_IDLE;
        if (pair) begin
          step_col();
          emit_token(op_kind(op, 1'b1), 16'd2);
          fin = 1'b1;
        end else if (op == "&" || op == "|") begin
          emit_error(ST_BAD);
        end else begin
          emit_token(op_kind(op, 1'b0), 16'd1);
        end
      end else if (scan_state == LX_LITERAL || scan_state == LX_ESCAPE) begin
        fin = 1'b1;
        if (b == CH_END) begin
          emit_error(ST_UNTERM);
        end else begin
          run_len = sat16(run_len);
          if (scan_state == LX_ESCAPE) begin
            scan_state = LX_LITERAL;
            step_col();
          end else if (b == (quote_dq ? CH_DQ : CH_SQ)) begin
            step_col();
            scan_state = LX_IDLE;
            emit_token(quote_dq ? K_STRING : K_CHAR_LIT, run_len);
          end else if (b == CH_BS) begin
            scan_state = LX_ESCAPE;
            step_col();
          end else if (b == CH_NL) begin
            new_line();
          end else begin
            step_col();
          end
        end
      end

      if (!fin && !lex_failed) begin
        if (b == CH_END) begin
          mark_start();
          emit_token(K_END, 16'd0);
          lex_restart();
        end else if (b == " " || b == CH_TAB || b == CH_CR) begin
          step_col();
        end else if (b == CH_NL) begin
          new_line();
        end else if (letter_or_us(b) || dec_digit(b)) begin
          mark_start();
          for (int i = 0; i < 6; i++) word_buf[i] = 8'h00;
          word_buf[0] = b;
          run_len = 16'd1;
          scan_state = dec_digit(b) ? LX_NUMBER : LX_WORD;
          step_col();
        end else if (b == CH_DQ || b == CH_SQ) begin
          mark_start();
          quote_dq = (b == CH_DQ);
          run_len = 16'd1;
          scan_state = LX_LITERAL;
          step_col();
        end else if (b == "!" || b == "=" || b == "<" || b == ">" || b == "&" || b == "|") begin
          mark_start();
          pend_op = b;
          scan_state = LX_OPERATOR;
          step_col();
        end else if (punct_kind(b) != K_END) begin
          mark_start();
          step_col();
          emit_token(punct_kind(b), 16'd1);
        end else begin
          mark_start();
          emit_error(ST_BAD);
        end
      end

      if (lex_failed) begin
        scan_state = LX_ERROR;
        if (b == CH_END) lex_restart();
      end
      if (step_out != 0) begin
        last_tok = pending_tokens.pop_back();
        last_tok.last = 1'b1;
        pending_tokens.push_back(last_tok);
      end
    end
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] exp);
    if (got !== exp)
      log_mismatch($sformatf("token %0d %s: got %0d, want %0d", rx_count, name, got, exp));
  endtask

  always @(posedge clk) begin : tok_check
    res_t want;
    if (!rst && tokens_if.valid && tokens_if.ready) begin
      rx_count++;
      if (tokens_if.status != ST_OK) rx_errors++;
      if (pending_tokens.size() == 0) begin
        log_mismatch($sformatf("token kind %0d with none expected", tokens_if.token_kind));
      end else begin
        want = pending_tokens.pop_front();
        check_field("kind", 16'(tokens_if.token_kind), 16'(want.kind));
        check_field("status", 16'(tokens_if.status), 16'(want.status));
        check_field("line", tokens_if.start_line, want.line);
        check_field("column", tokens_if.start_column, want.column);
        check_field("offset", tokens_if.start_offset, want.offset);
        check_field("length", tokens_if.token_length, want.length);
        check_field("last", 16'(tokens_if.last_of_item), 16'(want.last));
      end
    end
  end

  initial begin
    tokens_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold != 0) begin
        rx_hold--;
      end else begin
        rx_hold = $urandom_range(0, 4);
        tokens_if.ready <= rx_free || ($urandom_range(0, 2) != 0);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d tokens outstanding", cycles, pending_tokens.size());
    $display("Verification failed");
    $finish;
  end

  // called at a clock edge; returns at the edge that accepts the byte
  task automatic send_byte(input logic [7:0] b);
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 24);
      if (!tx_smooth) begin
        chars_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    tx_burst--;
    chars_if.valid <= 1'b1;
    chars_if.source_byte <= b;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    tx_count++;
    lex_byte(b);
  endtask

  task automatic drain();
    chars_if.valid <= 1'b0;
    tx_burst = 0;
    @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tok_limit = v;
  endtask

  task automatic row_typed(input logic [7:0] c, input logic [5:0] k, input logic [1:0] st);
    dir_row_t row;
    row.ch = c;
    row.typed = 1'b1;
    row.want = '{kind: k, status: st, line: 16'd1, column: 16'd1, offset: 16'd0,
                 length: 16'd0, last: 1'b1};
    dir_rows.push_back(row);
  endtask

  task automatic row_text(input string s);
    dir_row_t row;
    row.typed = 1'b0;
    row.want = '0;
    for (int i = 0; i < s.len(); i++) begin
      row.ch = s[i];
      dir_rows.push_back(row);
    end
  endtask

  task automatic row_byte(input logic [7:0] c);
    dir_row_t row;
    row.ch = c;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endtask

  function automatic logic [7:0] rand_letter();
    string set;
    set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  task automatic add_literal(input logic [7:0] q);
    src_q.push_back(q);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 7))
        0: begin
          src_q.push_back(CH_BS);
          src_q.push_back(8'($urandom_range(1, 255)));
        end
        1: src_q.push_back(CH_NL);
        2: src_q.push_back(8'($urandom_range(1, 255)));
        default: src_q.push_back(rand_letter());
      endcase
    end
    src_q.push_back(q);
  endtask

  task automatic add_token();
    string marks;
    int n;
    marks = "(){}[],;+-*/%";
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
        src_q.push_back(rand_letter());
        repeat (n - 1) src_q.push_back(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
      end
      3, 4: begin
        add_text(kw_spelling($urandom_range(0, 6)));
        if ($urandom_range(0, 4) == 0) src_q.push_back(rand_letter());
      end
      5, 6: repeat ($urandom_range(1, 6)) src_q.push_back(rand_digit());
      7: add_literal(CH_DQ);
      8: add_literal(CH_SQ);
      9, 10, 11, 12, 13: src_q.push_back(marks[$urandom_range(0, 12)]);
      14, 15, 16, 17: add_text(op_text($urandom_range(0, 9)));
      18: repeat ($urandom_range(1, 3)) src_q.push_back(" ");
      default: src_q.push_back(8'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic build_source();
    src_q.delete();
    src_count++;
    repeat ($urandom_range(1, 16)) begin
      add_token();
      case ($urandom_range(0, 7))
        0, 1: src_q.push_back(" ");
        2: src_q.push_back(CH_NL);
        3: src_q.push_back(CH_TAB);
        4: src_q.push_back(CH_CR);
        default: ;
      endcase
    end
    // broken endings
    case ($urandom_range(0, 11))
      0: src_q.push_back("&");
      1: src_q.push_back("|");
      2: src_q.push_back(CH_DQ);
      3: add_text("'x");
      default: ;
    endcase
    if ($urandom_range(0, 15) != 0) src_q.push_back(CH_END);
  endtask

  function automatic logic [15:0] plan_limit(input int p);
    case (p)
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd5;
      4: return 16'd30;
      default: return 16'd1024;
    endcase
  endfunction

  initial begin
    int start;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 16'd0;
    chars_if.valid <= 1'b0;
    chars_if.source_byte <= 8'h00;
    lex_restart();
    tok_limit = LIMIT_RESET;

    row_typed(CH_END, K_END, ST_OK);
    row_typed(8'hFF, K_END, ST_BAD);
    row_byte(CH_END);
    row_text("&");
    row_typed("x", K_END, ST_BAD);
    row_byte(CH_END);
    row_byte(CH_SQ);
    row_typed(CH_END, K_END, ST_UNTERM);
    row_text("if<=9\"\\\n\"\n!");
    row_byte(CH_END);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].ch);
      if (dir_rows[i].typed) begin
        repeat (step_out) pending_tokens.delete(pending_tokens.size() - 1);
        pending_tokens.push_back(dir_rows[i].want);
      end
    end
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p != 0) write_limit(plan_limit(p));
      rx_free = (p == 2);
      start = tx_count;
      while (tx_count - start < PHASE_BYTES) begin
        build_source();
        tx_smooth = ($urandom_range(0, 3) == 0);
        foreach (src_q[j]) send_byte(src_q[j]);
      end
      drain();
    end

    if (pending_tokens.size() != 0)
      log_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));
    $display("Summary: %0d bytes in %0d random sources plus a directed table",
             tx_count, src_count);
    $display("Summary: %0d tokens compared, %0d of them errors, token_limit 1 to 1024",
             rx_count, rx_errors);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/c_lex_pkg.sv
rtl/c_lex_if.sv
rtl/c_lex_front.sv
rtl/c_lex_scan.sv
rtl/c_lex_resq.sv
rtl/c_subset_lexer.sv
tb/sv/tb_c_subset_lexer.sv
